### hw/rtl/ocd_pkg.sv
// Package for the opcode class decoder: class codes, masks and decode functions.
`default_nettype none
package ocd_pkg;

  localparam int unsigned OpW  = 16;
  localparam int unsigned ClsW = 7;

  typedef logic [OpW-1:0]  op_t;
  typedef logic [ClsW-1:0] cls_t;

  localparam cls_t K_ILLEGAL = 7'd0,  K_ABCD = 7'd1,  K_ADD = 7'd2,  K_ADDA = 7'd3;
  localparam cls_t K_ADDI = 7'd4,  K_ADDQ = 7'd5,  K_ADDX = 7'd6,  K_AND = 7'd7;
  localparam cls_t K_ANDI = 7'd8,  K_ANDI2CCR = 7'd9, K_ANDI2SR = 7'd10, K_ASL = 7'd11;
  localparam cls_t K_ASR = 7'd12, K_BCC = 7'd13, K_BCHG_I = 7'd14, K_BCHG_R = 7'd15;
  localparam cls_t K_BCLR_I = 7'd16, K_BCLR_R = 7'd17, K_BCS = 7'd18, K_BEQ = 7'd19;
  localparam cls_t K_BGE = 7'd20, K_BGT = 7'd21, K_BHI = 7'd22, K_BLE = 7'd23;
  localparam cls_t K_BLS = 7'd24, K_BLT = 7'd25, K_BMI = 7'd26, K_BNE = 7'd27;
  localparam cls_t K_BPL = 7'd28, K_BRA = 7'd29, K_BSET_I = 7'd30, K_BSET_R = 7'd31;
  localparam cls_t K_BSR = 7'd32, K_BTST_I = 7'd33, K_BTST_R = 7'd34, K_BVC = 7'd35;
  localparam cls_t K_BVS = 7'd36, K_CHK = 7'd37, K_CLR = 7'd38, K_CMP = 7'd39;
  localparam cls_t K_CMPA = 7'd40, K_CMPI = 7'd41, K_CMPM = 7'd42, K_DBCC = 7'd43;
  localparam cls_t K_DIVS = 7'd44, K_DIVU = 7'd45, K_EOR = 7'd46, K_EORI = 7'd47;
  localparam cls_t K_EORI2CCR = 7'd48, K_EXG = 7'd49, K_EXT = 7'd50, K_JMP = 7'd51;
  localparam cls_t K_JSR = 7'd52, K_LEA = 7'd53, K_LINK = 7'd54, K_LSL = 7'd55;
  localparam cls_t K_LSR = 7'd56, K_MOVE = 7'd57, K_MOVE2CCR = 7'd58, K_MOVEA = 7'd59;
  localparam cls_t K_MOVEM = 7'd60, K_MOVEP = 7'd61, K_MOVEQ = 7'd62, K_MOVESR = 7'd63;
  localparam cls_t K_MULS = 7'd64, K_MULU = 7'd65, K_NBCD = 7'd66, K_NEG = 7'd67;
  localparam cls_t K_NEGX = 7'd68, K_NOP = 7'd69, K_NOT = 7'd70, K_OR = 7'd71;
  localparam cls_t K_ORI = 7'd72, K_ORI2CCR = 7'd73, K_PEA = 7'd74, K_ROL = 7'd75;
  localparam cls_t K_ROR = 7'd76, K_ROXL = 7'd77, K_ROXR = 7'd78, K_RTR = 7'd79;
  localparam cls_t K_RTS = 7'd80, K_SBCD = 7'd81, K_SCC = 7'd82, K_SUB = 7'd83;
  localparam cls_t K_SUBA = 7'd84, K_SUBI = 7'd85, K_SUBQ = 7'd86, K_SUBX = 7'd87;
  localparam cls_t K_SWAP = 7'd88, K_TAS = 7'd89, K_TRAP = 7'd90, K_TRAPV = 7'd91;
  localparam cls_t K_TST = 7'd92, K_UNLK = 7'd93;

  localparam logic [11:0] M_ALL  = 12'hFFF;
  localparam logic [11:0] M_DATA = 12'hBFF;
  localparam logic [11:0] M_MEMA = 12'h3F8;
  localparam logic [11:0] M_DALT = 12'hBF8;
  localparam logic [11:0] M_ALT  = 12'hFF8;
  localparam logic [11:0] M_BTI  = 12'hBFB;
  localparam logic [11:0] M_CTL  = 12'h27B;
  localparam logic [11:0] M_MMR  = 12'h2F8;
  localparam logic [11:0] M_MRM  = 12'h37B;

  function automatic logic ea_ok(input logic [5:0] ea, input logic [11:0] mask);
    logic ok;
    ok = 1'b0;
    if (ea[5:3] != 3'd7) ok = mask[4'd11 - {1'b0, ea[5:3]}];
    else begin
      case (ea[2:0])
        3'd0:    ok = mask[4];
        3'd1:    ok = mask[3];
        3'd2:    ok = mask[1];
        3'd3:    ok = mask[0];
        3'd4:    ok = mask[2];
        default: ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

  function automatic cls_t branch_cls(input logic [3:0] cc);
    cls_t r;
    case (cc)
      4'h0: r = K_BRA;  4'h1: r = K_BSR;  4'h2: r = K_BHI;  4'h3: r = K_BLS;
      4'h4: r = K_BCC;  4'h5: r = K_BCS;  4'h6: r = K_BNE;  4'h7: r = K_BEQ;
      4'h8: r = K_BVC;  4'h9: r = K_BVS;  4'hA: r = K_BPL;  4'hB: r = K_BMI;
      4'hC: r = K_BGE;  4'hD: r = K_BLT;  4'hE: r = K_BGT;  default: r = K_BLE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ocd_classify.sv
// Combinational opcode pattern matcher; later patterns take priority.
`default_nettype none
module ocd_classify (
  input  ocd_pkg::op_t  op,
  output ocd_pkg::cls_t cls
);
  import ocd_pkg::*;

  logic [3:0] hi;
  logic [2:0] opm;
  logic       szok, left;
  logic [5:0] ea, dst;

  assign hi   = op[15:12];
  assign opm  = op[8:6];
  assign szok = (op[7:6] != 2'd3);
  assign left = op[8];
  assign ea   = op[5:0];
  assign dst  = {op[8:6], op[11:9]};

  always_comb begin
    cls = K_ILLEGAL;
    if ((op & 16'hF1F0) == 16'hC100) cls = K_ABCD;
    if ((op & 16'hF1F0) == 16'h8100) cls = K_SBCD;
    if (opm <= 3'd2) begin
      if (hi == 4'hD) cls = K_ADD;
      if (hi == 4'hB) cls = K_CMP;
      if (hi == 4'h9) cls = K_SUB;
      if (hi == 4'hC && ea_ok(ea, M_DATA)) cls = K_AND;
      if (hi == 4'h8 && ea_ok(ea, M_DATA)) cls = K_OR;
    end else if (opm >= 3'd4 && opm <= 3'd6) begin
      if (ea_ok(ea, M_MEMA)) begin
        if (hi == 4'hD) cls = K_ADD;
        if (hi == 4'h9) cls = K_SUB;
        if (hi == 4'hC) cls = K_AND;
        if (hi == 4'hB) cls = K_EOR;
        if (hi == 4'h8) cls = K_OR;
      end
    end else begin
      if (hi == 4'hD) cls = K_ADDA;
      if (hi == 4'hB) cls = K_CMPA;
      if (hi == 4'h9) cls = K_SUBA;
    end
    if (szok && ea_ok(ea, M_DALT)) begin
      case (op[15:8])
        8'h06:   cls = K_ADDI;
        8'h02:   cls = K_ANDI;
        8'h0C:   cls = K_CMPI;
        8'h0A:   cls = K_EORI;
        8'h00:   cls = K_ORI;
        8'h04:   cls = K_SUBI;
        default: ;
      endcase
    end
    if (hi == 4'h5 && szok && ea_ok(ea, M_ALT)) cls = left ? K_SUBQ : K_ADDQ;
    if (szok && (op & 16'hF130) == 16'hD100) cls = K_ADDX;
    if (szok && (op & 16'hF130) == 16'h9100) cls = K_SUBX;
    if (op == 16'h023C) cls = K_ANDI2CCR;
    if (op == 16'h027C) cls = K_ANDI2SR;
    if (szok && (op & 16'hF018) == 16'hE008) cls = left ? K_LSL : K_LSR;
    if (szok && (op & 16'hF018) == 16'hE000) cls = left ? K_ASL : K_ASR;
    if (ea_ok(ea, M_MEMA)) begin
      if ((op & 16'hFEC0) == 16'hE2C0) cls = left ? K_LSL : K_LSR;
      if ((op & 16'hFEC0) == 16'hE0C0) cls = left ? K_ASL : K_ASR;
    end
    if (hi == 4'h6) cls = branch_cls(op[11:8]);
    if ((op & 16'hF100) == 16'h0100 && ea_ok(ea, M_DALT)) begin
      if (opm == 3'd5) cls = K_BCHG_R;
      if (opm == 3'd6) cls = K_BCLR_R;
      if (opm == 3'd7) cls = K_BSET_R;
    end
    if (ea_ok(ea, M_DALT)) begin
      if ((op & 16'hFFC0) == 16'h0840) cls = K_BCHG_I;
      if ((op & 16'hFFC0) == 16'h0880) cls = K_BCLR_I;
      if ((op & 16'hFFC0) == 16'h08C0) cls = K_BSET_I;
    end
    if ((op & 16'hF1C0) == 16'h0100 && ea_ok(ea, M_DATA)) cls = K_BTST_R;
    if ((op & 16'hFFC0) == 16'h0800 && ea_ok(ea, M_BTI)) cls = K_BTST_I;
    if ((op & 16'hF1C0) == 16'h4180 && ea_ok(ea, M_DATA)) cls = K_CHK;
    if ((op & 16'hFF00) == 16'h4200 && szok && ea_ok(ea, M_DALT)) cls = K_CLR;
    if ((op & 16'hF138) == 16'hB108 && szok) cls = K_CMPM;
    if ((op & 16'hF0F8) == 16'h50C8) cls = K_DBCC;
    if (ea_ok(ea, M_DATA)) begin
      case (op & 16'hF1C0)
        16'h81C0: cls = K_DIVS;
        16'h80C0: cls = K_DIVU;
        16'hC1C0: cls = K_MULS;
        16'hC0C0: cls = K_MULU;
        default:  ;
      endcase
    end
    if (op == 16'h0A3C) cls = K_EORI2CCR;
    if ((op & 16'hF1F8) == 16'hC140 || (op & 16'hF1F8) == 16'hC148 ||
        (op & 16'hF1F8) == 16'hC188) cls = K_EXG;
    if ((op & 16'hFFF8) == 16'h4880 || (op & 16'hFFF8) == 16'h48C0) cls = K_EXT;
    if (ea_ok(ea, M_CTL)) begin
      if ((op & 16'hFFC0) == 16'h4EC0) cls = K_JMP;
      if ((op & 16'hFFC0) == 16'h4E80) cls = K_JSR;
      if ((op & 16'hF1C0) == 16'h41C0) cls = K_LEA;
    end
    if ((op & 16'hFFF8) == 16'h4E50) cls = K_LINK;
    if (hi >= 4'h1 && hi <= 4'h3 && ea_ok(dst, M_DALT) && ea_ok(ea, M_ALL)) cls = K_MOVE;
    if ((hi == 4'h2 || hi == 4'h3) && opm == 3'd1) cls = K_MOVEA;
    if ((op & 16'hFFC0) == 16'h44C0 && ea_ok(ea, M_DATA)) cls = K_MOVE2CCR;
    if ((op & 16'hFFC0) == 16'h40C0 && ea_ok(ea, M_DALT)) cls = K_MOVESR;
    if ((op & 16'hFF80) == 16'h4880 && ea_ok(ea, M_MMR)) cls = K_MOVEM;
    if ((op & 16'hFF80) == 16'h4C80 && ea_ok(ea, M_MRM)) cls = K_MOVEM;
    if ((op & 16'hF138) == 16'h0108) cls = K_MOVEP;
    if ((op & 16'hF100) == 16'h7000) cls = K_MOVEQ;
    if ((op & 16'hFFC0) == 16'h4800 && ea_ok(ea, M_DALT)) cls = K_NBCD;
    if (szok && ea_ok(ea, M_DALT)) begin
      if (op[15:8] == 8'h44) cls = K_NEG;
      if (op[15:8] == 8'h40) cls = K_NEGX;
      if (op[15:8] == 8'h46) cls = K_NOT;
    end
    if (op == 16'h4E71) cls = K_NOP;
    if (op == 16'h003C) cls = K_ORI2CCR;
    if ((op & 16'hFFC0) == 16'h4840 && ea_ok(ea, M_CTL)) cls = K_PEA;
    if (szok && (op & 16'hF018) == 16'hE018) cls = left ? K_ROL : K_ROR;
    if (szok && (op & 16'hF018) == 16'hE010) cls = left ? K_ROXL : K_ROXR;
    if (ea_ok(ea, M_MEMA)) begin
      if ((op & 16'hFEC0) == 16'hE6C0) cls = left ? K_ROL : K_ROR;
      if ((op & 16'hFEC0) == 16'hE4C0) cls = left ? K_ROXL : K_ROXR;
    end
    if (op == 16'h4E77) cls = K_RTR;
    if (op == 16'h4E75) cls = K_RTS;
    if ((op & 16'hF0C0) == 16'h50C0 && ea_ok(ea, M_DALT)) cls = K_SCC;
    if ((op & 16'hFFF8) == 16'h4840) cls = K_SWAP;
    if ((op & 16'hFFC0) == 16'h4AC0 && ea_ok(ea, M_DALT)) cls = K_TAS;
    if ((op & 16'hFFF0) == 16'h4E40) cls = K_TRAP;
    if (op == 16'h4E76) cls = K_TRAPV;
    if (op[15:8] == 8'h4A && szok) cls = K_TST;
    if ((op & 16'hFFF8) == 16'h4E58) cls = K_UNLK;
  end
endmodule
`default_nettype wire

### hw/rtl/opcode_class_decoder_top.sv
// Top level of the opcode class decoder: input register, matcher, result register.
// The input register feeds the matcher, whose class is captured in the result register.
// Throughput: one opcode per cycle while out_ready does not stall the result; the matcher is a single pass of logic.
// A stalled result holds both stages; a free stage accepts the next transaction.
// Reset (synchronous, rst_n low) clears both valid flags; payload is not reset.
`default_nettype none
module opcode_class_decoder_top (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  ocd_pkg::op_t   in_opcode_word,
  output logic           out_valid,
  input  wire            out_ready,
  output ocd_pkg::cls_t  out_instr_class,
  output logic           out_is_illegal
);
  import ocd_pkg::*;

  logic  op_vld_r;
  op_t   op_r;
  cls_t  cls_c;
  logic  adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !op_vld_r || adv;

  ocd_classify u_cls (.op(op_r), .cls(cls_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) op_vld_r <= in_valid;
      if (adv) out_valid <= op_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) op_r <= in_opcode_word;
    if (adv && op_vld_r) begin
      out_instr_class <= cls_c;
      out_is_illegal  <= (cls_c == K_ILLEGAL);
    end
  end

`ifndef NO_ASSERTIONS
  a_ill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_illegal == (out_instr_class == K_ILLEGAL)))
    else $error("illegal flag disagrees with class");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_instr_class <= K_UNLK))
    else $error("class out of range");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (op_vld_r && adv) |=> out_valid)
    else $error("decoded transaction lost");
`endif
endmodule
`default_nettype wire
